FILE: design/dns_qname_label_encoder_assert.svh
// Assertion macros for the DNS name label encoder.
`ifndef DNS_QNAME_LABEL_ENCODER_ASSERT_SVH
`define DNS_QNAME_LABEL_ENCODER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define DQLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define DQLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dqle_pkg.sv
// Types and constants shared by the DNS name label encoder.
`default_nettype none

package dqle_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;

    localparam logic [BYTE_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_TERM
    } state_t;

    typedef struct packed {
        logic              append;
        logic              shift;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] char_byte;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/dns_qname_label_encoder.sv
// Latency: a character beat is absorbed on acceptance; no output follows it. A dot or end mark
// with an n-character label (n nonzero) gives n+1 output beats, one per cycle while m_ready allows:
// the length byte, registered out of ST_LEN, then the label bytes; an end mark adds the terminator.
// Throughput: 1 character per cycle in ST_IDLE; input stalls after a dot or end mark until the label
// is sent, as the cell chain shifts one byte per cycle toward its head while the output can advance.
// Reset (aresetn low, sync) clears count, state, overflow/end flags, valid; not data bytes.
`default_nettype none

module dns_qname_label_encoder #(
    parameter int LABEL_MAX = 62
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_byte,
    input  wire logic       s_end_mark,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_out_byte,
    output logic            m_last,
    output logic            m_name_overflow
);

`include "dns_qname_label_encoder_assert.svh"

    localparam int ByteW = dqle_pkg::BYTE_W;
    localparam int CntW  = dqle_pkg::CNT_W;

    dqle_pkg::state_t     state_reg, state_next;
    logic [CntW-1:0]      label_count_reg, label_count_next;
    logic                 overflow_reg, overflow_next;
    logic                 end_pend_reg, end_pend_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ByteW-1:0]     m_byte_reg, m_byte_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_ovf_reg, m_ovf_next;

    dqle_pkg::cell_ctrl_t cell_ctrl;
    logic [ByteW-1:0]     cell_data [LABEL_MAX];
    logic [ByteW-1:0]     folded;
    logic                 is_dot;
    logic                 in_fire;
    logic                 out_adv;
    logic                 label_full;

    assign in_fire    = s_valid && s_ready;
    assign out_adv    = !m_valid_reg || m_ready;
    assign is_dot     = (folded == dqle_pkg::CH_DOT);
    assign label_full = (label_count_reg >= CntW'(LABEL_MAX));

    always_comb begin
        if (s_char_byte >= dqle_pkg::CH_UPPER_A && s_char_byte <= dqle_pkg::CH_UPPER_Z) begin
            folded = s_char_byte + dqle_pkg::CASE_OFFSET;
        end else begin
            folded = s_char_byte;
        end
    end

    // label chain
    for (genvar i = 0; i < LABEL_MAX; i++) begin : g_cell
        logic [ByteW-1:0] nb;
        if (i == LABEL_MAX - 1) begin : g_tail
            assign nb = '0;
        end else begin : g_mid
            assign nb = cell_data[i+1];
        end
        dqle_cell #(
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .next_byte (nb),
            .data      (cell_data[i])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dqle_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (s_end_mark) begin
                        state_next = (label_count_reg != '0) ? dqle_pkg::ST_LEN
                                                             : dqle_pkg::ST_TERM;
                    end else if (is_dot && label_count_reg != '0) begin
                        state_next = dqle_pkg::ST_LEN;
                    end
                end
            end
            dqle_pkg::ST_LEN: begin
                if (out_adv) begin
                    state_next = dqle_pkg::ST_DATA;
                end
            end
            dqle_pkg::ST_DATA: begin
                if (out_adv && label_count_reg == CntW'(1)) begin
                    state_next = end_pend_reg ? dqle_pkg::ST_TERM : dqle_pkg::ST_IDLE;
                end
            end
            dqle_pkg::ST_TERM: begin
                if (out_adv) begin
                    state_next = dqle_pkg::ST_IDLE;
                end
            end
            default: state_next = dqle_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready               = (state_reg == dqle_pkg::ST_IDLE);
        label_count_next      = label_count_reg;
        overflow_next         = overflow_reg;
        end_pend_next         = end_pend_reg;
        m_valid_next          = out_adv ? 1'b0 : m_valid_reg;
        m_byte_next           = m_byte_reg;
        m_last_next           = m_last_reg;
        m_ovf_next            = m_ovf_reg;
        cell_ctrl.append      = 1'b0;
        cell_ctrl.shift       = 1'b0;
        cell_ctrl.count       = label_count_reg;
        cell_ctrl.char_byte   = folded;
        unique case (state_reg)
            dqle_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (s_end_mark) begin
                        end_pend_next = 1'b1;
                    end else if (is_dot) begin
                        end_pend_next = 1'b0;
                    end else if (!label_full) begin
                        cell_ctrl.append = 1'b1;
                        label_count_next = label_count_reg + CntW'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
            end
            dqle_pkg::ST_LEN: begin
                if (out_adv) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = {{(ByteW-CntW){1'b0}}, label_count_reg};
                    m_last_next  = 1'b0;
                    m_ovf_next   = 1'b0;
                end
            end
            dqle_pkg::ST_DATA: begin
                if (out_adv) begin
                    m_valid_next     = 1'b1;
                    m_byte_next      = cell_data[0];
                    m_last_next      = 1'b0;
                    m_ovf_next       = 1'b0;
                    cell_ctrl.shift  = 1'b1;
                    label_count_next = label_count_reg - CntW'(1);
                end
            end
            dqle_pkg::ST_TERM: begin
                if (out_adv) begin
                    m_valid_next     = 1'b1;
                    m_byte_next      = '0;
                    m_last_next      = 1'b1;
                    m_ovf_next       = overflow_reg;
                    overflow_next    = 1'b0;
                    label_count_next = '0;
                    end_pend_next    = 1'b0;
                end
            end
            default: begin
                m_valid_next = m_valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= dqle_pkg::ST_IDLE;
            label_count_reg <= '0;
            overflow_reg    <= 1'b0;
            end_pend_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            label_count_reg <= label_count_next;
            overflow_reg    <= overflow_next;
            end_pend_reg    <= end_pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_last          = m_last_reg;
    assign m_name_overflow = m_ovf_reg;

    `DQLE_ASSERT_NOW(a_count_bound, 1'b1, label_count_reg <= CntW'(LABEL_MAX), "label count past limit")
    `DQLE_ASSERT_NOW(a_drain_nonempty, state_reg == dqle_pkg::ST_DATA, label_count_reg != '0, "draining empty label")
    `DQLE_ASSERT_NOW(a_term_zero, m_valid_reg && m_last_reg, m_byte_reg == '0, "terminator beat not clean")
    `DQLE_ASSERT_NEXT(a_empty_end, in_fire && s_end_mark && label_count_reg == '0, state_reg == dqle_pkg::ST_TERM, "empty name missed terminator")

endmodule

`default_nettype wire

FILE: design/dqle_cell.sv
// One byte cell of the label chain: loads a character at its slot or takes its neighbor's byte.
`default_nettype none

module dqle_cell #(
    parameter int IDX = 0
) (
    input  wire logic                          aclk,
    input  wire dqle_pkg::cell_ctrl_t          ctrl,
    input  wire logic [dqle_pkg::BYTE_W-1:0]   next_byte,
    output logic      [dqle_pkg::BYTE_W-1:0]   data
);

    logic [dqle_pkg::BYTE_W-1:0] data_reg;
    logic                        slot_hit;

    assign slot_hit = (ctrl.count == dqle_pkg::CNT_W'(IDX));

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            data_reg <= next_byte;
        end else if (ctrl.append && slot_hit) begin
            data_reg <= ctrl.char_byte;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire
